@@ hdl/hhtr_pkg.sv @@
// ============================================================================
// Huffman header tree rebuild package
// Shared constants, command and record types for the tree rebuild block.
// ============================================================================
package hhtr_pkg;

    localparam int BYTE_W          = 8;
    localparam int ID_OUT_W        = 9;
    localparam int DEF_STACK_DEPTH = 256;
    localparam int DEF_MAX_NODES   = 512;

    // Command queue between the parser and the stack engine.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [BYTE_W-1:0] LEAF_CMD    = 8'd49;
    localparam logic [BYTE_W-1:0] INNER_VALUE = 8'd32;

    localparam logic MODE_CHAR   = 1'b0;
    localparam logic MODE_PACKED = 1'b1;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_LEAF    = 2'd1,
        CMD_COMBINE = 2'd2
    } t_cmd_kind;

    // One queued command. A NONE command only carries a clear request.
    typedef struct packed {
        t_cmd_kind         kind;
        logic              clear;
        logic              last;
        logic [BYTE_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic [ID_OUT_W-1:0] node_id;
        logic                is_leaf;
        logic [BYTE_W-1:0]   leaf_value;
        logic [ID_OUT_W-1:0] left_id;
        logic [ID_OUT_W-1:0] right_id;
        logic                tree_done;
        logic                header_error;
        logic                last_of_run;
    } t_rec;

endpackage

@@ hdl/hhtr_if.sv @@
// ============================================================================
// Huffman header tree rebuild interfaces
// Valid/ready channels for header bytes, node records and the mode register.
// ============================================================================
interface hhtr_hdr_if;
    logic       valid;
    logic       ready;
    logic [7:0] header_byte;
    logic       start_header;

    modport source(output valid, output header_byte, output start_header, input ready);
    modport sink(input valid, input header_byte, input start_header, output ready);
endinterface

interface hhtr_rec_if;
    logic       valid;
    logic       ready;
    logic [8:0] node_id;
    logic       is_leaf;
    logic [7:0] leaf_value;
    logic [8:0] left_id;
    logic [8:0] right_id;
    logic       tree_done;
    logic       header_error;
    logic       last_of_run;

    modport source(output valid, output node_id, output is_leaf, output leaf_value,
                   output left_id, output right_id, output tree_done,
                   output header_error, output last_of_run, input ready);
    modport sink(input valid, input node_id, input is_leaf, input leaf_value,
                 input left_id, input right_id, input tree_done,
                 input header_error, input last_of_run, output ready);
endinterface

interface hhtr_cfg_if;
    logic valid;
    logic ready;
    logic header_mode;

    modport source(output valid, output header_mode, input ready);
    modport sink(input valid, input header_mode, output ready);
endinterface

@@ hdl/hhtr_ram.sv @@
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module hhtr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/hhtr_front.sv @@
// ============================================================================
// Header parser
// Walks each header byte and turns it into leaf and combine commands.
// ============================================================================
module hhtr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_mode,
    hhtr_hdr_if.sink      i_hdr,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output hhtr_pkg::t_cmd o_cmd
);
    import hhtr_pkg::*;

    logic              r_busy, n_busy;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic [2:0]        r_pos, n_pos;
    logic              r_clr, n_clr;
    logic              r_await, n_await;
    logic [2:0]        r_held, n_held;
    logic [BYTE_W-1:0] r_shift, n_shift;

    logic              cur_bit;
    t_cmd_kind         kind;
    logic [BYTE_W-1:0] value;
    logic              s_await;
    logic [2:0]        s_held;
    logic [BYTE_W-1:0] s_shift;
    logic              last_step;
    logic              more;
    logic              push;
    logic              step_go;
    logic              accept;

    // True if a command still follows in the bits after position pos.
    function automatic logic f_more(input logic [BYTE_W-1:0] byt, input logic [2:0] pos,
                                    input logic aw, input logic [2:0] held);
        logic       a;
        logic [2:0] h;
        logic       found;
        logic       bv;
        a     = aw;
        h     = held;
        found = 1'b0;
        for (int k = 0; k < 8; k++) begin
            if (3'(k) > pos) begin
                bv = byt[3'(7 - k)];
                if (a) begin
                    if (h == 3'd7) begin
                        found = 1'b1;
                        a     = 1'b0;
                        h     = 3'd0;
                    end else begin
                        h = h + 3'd1;
                    end
                end else if (bv) begin
                    a = 1'b1;
                    h = 3'd0;
                end else begin
                    found = 1'b1;
                end
            end
        end
        return found;
    endfunction

    always_comb begin
        cur_bit = r_byte[3'd7 - r_pos];
        kind    = CMD_NONE;
        value   = '0;
        s_await = r_await;
        s_held  = r_held;
        s_shift = r_shift;
        if (i_mode == MODE_CHAR) begin
            if (r_await) begin
                kind    = CMD_LEAF;
                value   = r_byte;
                s_await = 1'b0;
                s_held  = '0;
                s_shift = '0;
            end else if (r_byte == LEAF_CMD) begin
                s_await = 1'b1;
                s_held  = '0;
                s_shift = '0;
            end else begin
                kind = CMD_COMBINE;
            end
        end else begin
            if (r_await) begin
                if (r_held == 3'd7) begin
                    kind    = CMD_LEAF;
                    value   = {r_shift[BYTE_W-2:0], cur_bit};
                    s_await = 1'b0;
                    s_held  = '0;
                    s_shift = '0;
                end else begin
                    s_held  = r_held + 3'd1;
                    s_shift = {r_shift[BYTE_W-2:0], cur_bit};
                end
            end else if (cur_bit) begin
                s_await = 1'b1;
                s_held  = '0;
                s_shift = '0;
            end else begin
                kind = CMD_COMBINE;
            end
        end
    end

    assign last_step = (i_mode == MODE_CHAR) || (r_pos == 3'd7);
    assign more      = (i_mode == MODE_PACKED) && f_more(r_byte, r_pos, s_await, s_held);
    assign push      = r_busy && ((kind != CMD_NONE) || (last_step && r_clr));
    assign step_go   = r_busy && (!push || i_cmd_ready);

    assign i_hdr.ready = !r_busy || (step_go && last_step);
    assign accept      = i_hdr.valid && i_hdr.ready;

    assign o_cmd_valid  = push;
    assign o_cmd.kind   = kind;
    assign o_cmd.clear  = r_clr;
    assign o_cmd.last   = !more;
    assign o_cmd.value  = value;

    always_comb begin
        n_busy  = r_busy;
        n_byte  = r_byte;
        n_pos   = r_pos;
        n_clr   = r_clr;
        n_await = r_await;
        n_held  = r_held;
        n_shift = r_shift;
        if (step_go) begin
            n_await = s_await;
            n_held  = s_held;
            n_shift = s_shift;
            n_pos   = r_pos + 3'd1;
            if (push) begin
                n_clr = 1'b0;
            end
            if (last_step) begin
                n_busy = 1'b0;
            end
        end
        if (accept) begin
            n_byte = i_hdr.header_byte;
            n_pos  = '0;
            n_busy = 1'b1;
            n_clr  = i_hdr.start_header;
            if (i_hdr.start_header) begin
                n_await = 1'b0;
                n_held  = '0;
                n_shift = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_pos   <= '0;
            r_clr   <= 1'b0;
            r_await <= 1'b0;
            r_held  <= '0;
            r_shift <= '0;
        end else begin
            r_busy  <= n_busy;
            r_pos   <= n_pos;
            r_clr   <= n_clr;
            r_await <= n_await;
            r_held  <= n_held;
            r_shift <= n_shift;
        end
        r_byte <= n_byte;
    end

endmodule

@@ hdl/hhtr_fifo.sv @@
// ============================================================================
// Command queue
// Short register queue that decouples the parser from the stack engine.
// ============================================================================
module hhtr_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  hhtr_pkg::t_cmd i_push_data,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output hhtr_pkg::t_cmd o_pop_data
);
    import hhtr_pkg::*;

    t_cmd                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wptr;
    logic [FIFO_PTR_W-1:0] r_rptr;
    logic [FIFO_CNT_W-1:0] r_cnt;
    logic                  push;
    logic                  pop;

    assign o_push_ready = (r_cnt != FIFO_CNT_W'(FIFO_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

@@ hdl/hhtr_back.sv @@
// ============================================================================
// Stack engine
// Runs leaf and combine commands on the node stack and emits node records.
// ============================================================================
module hhtr_back #(
    parameter int STACK_DEPTH = hhtr_pkg::DEF_STACK_DEPTH,
    parameter int MAX_NODES   = hhtr_pkg::DEF_MAX_NODES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  hhtr_pkg::t_cmd i_cmd,
    hhtr_rec_if.source     o_rec
);
    import hhtr_pkg::*;

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int NODE_W = $clog2(MAX_NODES + 1);
    localparam int ID_W   = $clog2(MAX_NODES);

    typedef enum logic [1:0] {
        ST_RUN  = 2'b01,
        ST_COMB = 2'b10
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [NODE_W-1:0] r_next, n_next;
    logic [ID_W-1:0]   r_top, n_top;
    logic              r_fin, n_fin;
    logic              r_err, n_err;
    logic              r_last, n_last;
    logic              r_ov, n_ov;
    t_rec              r_rec, n_rec;

    logic [CNT_W-1:0]  eff_cnt;
    logic [NODE_W-1:0] eff_next;
    logic              eff_fin;
    logic              eff_err;
    logic              out_free;
    logic              pop;
    t_rec              rec;
    logic              rec_v;
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [ID_W-1:0]   rdata;

    // Entries below the top live in the RAM; the top entry is kept in r_top.
    hhtr_ram #(
        .WIDTH(ID_W),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(r_top),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign out_free = !r_ov || o_rec.ready;
    assign eff_cnt  = i_cmd.clear ? '0 : r_cnt;
    assign eff_next = i_cmd.clear ? '0 : r_next;
    assign eff_fin  = i_cmd.clear ? 1'b0 : r_fin;
    assign eff_err  = i_cmd.clear ? 1'b0 : r_err;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_next  = r_next;
        n_top   = r_top;
        n_fin   = r_fin;
        n_err   = r_err;
        n_last  = r_last;
        pop     = 1'b0;
        rec     = '0;
        rec_v   = 1'b0;
        we      = 1'b0;
        re      = 1'b0;
        waddr   = ADDR_W'(eff_cnt - 1'b1);
        raddr   = ADDR_W'(eff_cnt - 2'd2);
        unique case (r_state)
            ST_RUN: begin
                if (i_cmd_valid && out_free) begin
                    pop    = 1'b1;
                    n_cnt  = eff_cnt;
                    n_next = eff_next;
                    n_fin  = eff_fin;
                    n_err  = eff_err;
                    if (!(eff_fin || eff_err)) begin
                        unique case (i_cmd.kind)
                            CMD_LEAF: begin
                                if (eff_next >= NODE_W'(MAX_NODES) ||
                                    eff_cnt >= CNT_W'(STACK_DEPTH)) begin
                                    rec.header_error = 1'b1;
                                    rec.last_of_run  = 1'b1;
                                    rec_v            = 1'b1;
                                    n_err            = 1'b1;
                                end else begin
                                    we              = (eff_cnt != '0);
                                    rec.node_id     = ID_OUT_W'(eff_next[ID_W-1:0]);
                                    rec.is_leaf     = 1'b1;
                                    rec.leaf_value  = i_cmd.value;
                                    rec.last_of_run = i_cmd.last;
                                    rec_v           = 1'b1;
                                    n_top           = eff_next[ID_W-1:0];
                                    n_cnt           = eff_cnt + 1'b1;
                                    n_next          = eff_next + 1'b1;
                                end
                            end
                            CMD_COMBINE: begin
                                if (eff_cnt == '0) begin
                                    rec.header_error = 1'b1;
                                    rec.last_of_run  = 1'b1;
                                    rec_v            = 1'b1;
                                    n_err            = 1'b1;
                                end else if (eff_cnt == CNT_W'(1)) begin
                                    // The last entry popped is the root.
                                    rec.node_id     = ID_OUT_W'(r_top);
                                    rec.tree_done   = 1'b1;
                                    rec.last_of_run = 1'b1;
                                    rec_v           = 1'b1;
                                    n_fin           = 1'b1;
                                    n_cnt           = '0;
                                end else if (eff_next >= NODE_W'(MAX_NODES)) begin
                                    rec.header_error = 1'b1;
                                    rec.last_of_run  = 1'b1;
                                    rec_v            = 1'b1;
                                    n_err            = 1'b1;
                                end else begin
                                    re      = 1'b1;
                                    n_last  = i_cmd.last;
                                    n_state = ST_COMB;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            ST_COMB: begin
                if (out_free) begin
                    rec.node_id     = ID_OUT_W'(r_next[ID_W-1:0]);
                    rec.leaf_value  = INNER_VALUE;
                    rec.left_id     = ID_OUT_W'(rdata);
                    rec.right_id    = ID_OUT_W'(r_top);
                    rec.last_of_run = r_last;
                    rec_v           = 1'b1;
                    n_top           = r_next[ID_W-1:0];
                    n_cnt           = r_cnt - 1'b1;
                    n_next          = r_next + 1'b1;
                    n_state         = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_comb begin
        n_ov  = r_ov;
        n_rec = r_rec;
        if (rec_v) begin
            n_ov  = 1'b1;
            n_rec = rec;
        end else if (o_rec.ready) begin
            n_ov = 1'b0;
        end
    end

    assign o_cmd_ready        = pop;
    assign o_rec.valid        = r_ov;
    assign o_rec.node_id      = r_rec.node_id;
    assign o_rec.is_leaf      = r_rec.is_leaf;
    assign o_rec.leaf_value   = r_rec.leaf_value;
    assign o_rec.left_id      = r_rec.left_id;
    assign o_rec.right_id     = r_rec.right_id;
    assign o_rec.tree_done    = r_rec.tree_done;
    assign o_rec.header_error = r_rec.header_error;
    assign o_rec.last_of_run  = r_rec.last_of_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_cnt   <= '0;
            r_next  <= '0;
            r_fin   <= 1'b0;
            r_err   <= 1'b0;
            r_last  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_next  <= n_next;
            r_fin   <= n_fin;
            r_err   <= n_err;
            r_last  <= n_last;
            r_ov    <= n_ov;
        end
        r_top <= n_top;
        r_rec <= n_rec;
    end

endmodule

@@ hdl/huffman_header_tree_rebuild.sv @@
// Path: a header byte passes the parser's byte register, the command queue
// and the record register before its first node record is valid; an internal
// node also passes the ST_COMB state. The parser takes a character-mode byte
// in a single step and walks a packed byte one command bit per cycle while the
// command queue has room. In the stack engine a combine runs in ST_RUN and then
// ST_COMB, since the left child comes from the stack RAM's registered read
// port. Reset is synchronous and active low; the stack RAM is not cleared.
// ============================================================================
// Huffman header tree rebuild
// Rebuilds a Huffman tree from a post-order header, one byte per transfer.
// ============================================================================
module huffman_header_tree_rebuild #(
    parameter int STACK_DEPTH = hhtr_pkg::DEF_STACK_DEPTH,
    parameter int MAX_NODES   = hhtr_pkg::DEF_MAX_NODES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hhtr_cfg_if.sink   i_cfg,
    hhtr_hdr_if.sink   i_hdr,
    hhtr_rec_if.source o_rec
);
    import hhtr_pkg::*;

    // The header mode register. Writes are only expected while the block is
    // idle, so the parser samples it freely.
    logic r_mode;

    logic cmd_in_valid;
    logic cmd_in_ready;
    t_cmd cmd_in;
    logic cmd_out_valid;
    logic cmd_out_ready;
    t_cmd cmd_out;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_CHAR;
        end else if (i_cfg.valid) begin
            r_mode <= i_cfg.header_mode;
        end
    end

    // The parser splits each byte into leaf and combine commands. It tags
    // the command that ends a byte so the engine can flag the byte's last
    // record, and carries a start of header as a clear flag on the first
    // command of the byte (or on an empty command if the byte has none).
    hhtr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mode     (r_mode),
        .i_hdr      (i_hdr),
        .o_cmd_valid(cmd_in_valid),
        .i_cmd_ready(cmd_in_ready),
        .o_cmd      (cmd_in)
    );

    // The queue lets the parser run ahead while the engine waits on the
    // stack RAM or on the record sink.
    hhtr_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_valid(cmd_in_valid),
        .o_push_ready(cmd_in_ready),
        .i_push_data (cmd_in),
        .o_pop_valid (cmd_out_valid),
        .i_pop_ready (cmd_out_ready),
        .o_pop_data  (cmd_out)
    );

    // The engine owns the node stack, the node counter and the done and
    // error flags. After a done or an error record it drops every command
    // until one arrives with the clear flag set.
    hhtr_back #(
        .STACK_DEPTH(STACK_DEPTH),
        .MAX_NODES  (MAX_NODES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(cmd_out_valid),
        .o_cmd_ready(cmd_out_ready),
        .i_cmd      (cmd_out),
        .o_rec      (o_rec)
    );

endmodule

@@ test/hhtr_tree_board_pkg.sv @@
`timescale 1ns / 100ps
// ============================================================================
// Huffman header tree rebuild scoreboard
// Rebuilds the tree from every accepted header byte and holds the node
// records that the block has to send back, oldest first.
// ============================================================================
package hhtr_tree_board_pkg;

    import hhtr_pkg::*;

    class node_record_board;

        logic                mode;
        int                  fails;
        int                  records_seen;
        t_rec                pending_nodes[$];
        t_rec                byte_records[$];

        logic [ID_OUT_W-1:0] id_stack[DEF_STACK_DEPTH];
        logic [8:0]          depth;
        logic [9:0]          next_id;
        logic                want_value;
        logic [3:0]          value_bits;
        logic [7:0]          value_acc;
        logic                tree_closed;
        logic                error_latched;

        function new();
            fails        = 0;
            records_seen = 0;
            mode         = MODE_CHAR;
            wipe();
        endfunction

        // The stack entries are left alone: only entries below depth are read.
        function void wipe();
            depth         = '0;
            next_id       = '0;
            want_value    = 1'b0;
            value_bits    = '0;
            value_acc     = '0;
            tree_closed   = 1'b0;
            error_latched = 1'b0;
        endfunction

        function t_rec node_rec(logic [8:0] id, logic leaf, logic [7:0] val,
                                logic [8:0] lhs, logic [8:0] rhs, logic done,
                                logic err);
            t_rec r;
            r.node_id      = id;
            r.is_leaf      = leaf;
            r.leaf_value   = val;
            r.left_id      = lhs;
            r.right_id     = rhs;
            r.tree_done    = done;
            r.header_error = err;
            r.last_of_run  = 1'b0;
            return r;
        endfunction

        function void raise_error();
            error_latched = 1'b1;
            byte_records.push_back(node_rec('0, 1'b0, '0, '0, '0, 1'b0, 1'b1));
        endfunction

        function bit push_leaf(logic [7:0] val);
            if (next_id >= DEF_MAX_NODES || depth >= DEF_STACK_DEPTH) begin
                raise_error();
                return 0;
            end
            id_stack[depth[7:0]] = next_id[8:0];
            depth++;
            byte_records.push_back(node_rec(next_id[8:0], 1'b1, val, '0, '0, 1'b0, 1'b0));
            next_id++;
            return 1;
        endfunction

        // Pops the right child, then the left one, and pushes the new parent.
        // A pop that empties the stack names the root instead.
        function bit merge_top();
            logic [8:0] rhs;
            logic [8:0] lhs;
            if (depth == 0) begin
                raise_error();
                return 0;
            end
            depth--;
            rhs = id_stack[depth[7:0]];
            if (depth == 0) begin
                tree_closed = 1'b1;
                byte_records.push_back(node_rec(rhs, 1'b0, '0, '0, '0, 1'b1, 1'b0));
                return 0;
            end
            if (next_id >= DEF_MAX_NODES) begin
                raise_error();
                return 0;
            end
            depth--;
            lhs = id_stack[depth[7:0]];
            id_stack[depth[7:0]] = next_id[8:0];
            depth++;
            byte_records.push_back(node_rec(next_id[8:0], 1'b0, INNER_VALUE, lhs, rhs,
                                            1'b0, 1'b0));
            next_id++;
            return 1;
        endfunction

        // Notes one accepted header byte. Returns 0 when the byte is ignored.
        function bit take_header(logic [7:0] hb, logic st);
            int         i;
            logic       b;
            logic [7:0] v;
            t_rec       tail;
            byte_records.delete();
            if (st) wipe();
            if (tree_closed || error_latched) return 0;
            if (mode == MODE_CHAR) begin
                if (want_value) begin
                    want_value = 1'b0;
                    value_bits = '0;
                    value_acc  = '0;
                    void'(push_leaf(hb));
                end else if (hb == LEAF_CMD) begin
                    want_value = 1'b1;
                    value_bits = '0;
                    value_acc  = '0;
                end else begin
                    void'(merge_top());
                end
            end else begin
                for (i = 7; i >= 0; i--) begin
                    b = hb[i];
                    if (want_value) begin
                        value_acc = {value_acc[6:0], b};
                        value_bits++;
                        if (value_bits >= 8) begin
                            v          = value_acc;
                            want_value = 1'b0;
                            value_bits = '0;
                            value_acc  = '0;
                            if (!push_leaf(v)) break;
                        end
                    end else if (b) begin
                        want_value = 1'b1;
                        value_bits = '0;
                        value_acc  = '0;
                    end else if (!merge_top()) begin
                        break;
                    end
                end
            end
            if (byte_records.size() > 0) begin
                tail = byte_records.pop_back();
                tail.last_of_run = 1'b1;
                byte_records.push_back(tail);
            end
            foreach (byte_records[k]) pending_nodes.push_back(byte_records[k]);
            return 1;
        endfunction

        task report(string msg);
            fails++;
            if (fails <= 200) $display("%0t ERROR %s", $time, msg);
        endtask

        task check_field(string name, int got_v, int want_v);
            if (got_v != want_v)
                report($sformatf("record %0d %s: got %0d, expected %0d",
                                 records_seen, name, got_v, want_v));
        endtask

        task match_record(t_rec got);
            t_rec want;
            records_seen++;
            if (pending_nodes.size() == 0) begin
                report($sformatf("record %0d arrived with none expected, node_id %0d",
                                 records_seen, got.node_id));
                return;
            end
            want = pending_nodes.pop_front();
            check_field("node_id", got.node_id, want.node_id);
            check_field("is_leaf", got.is_leaf, want.is_leaf);
            check_field("leaf_value", got.leaf_value, want.leaf_value);
            check_field("left_id", got.left_id, want.left_id);
            check_field("right_id", got.right_id, want.right_id);
            check_field("tree_done", got.tree_done, want.tree_done);
            check_field("header_error", got.header_error, want.header_error);
            check_field("last_of_run", got.last_of_run, want.last_of_run);
        endtask

    endclass

endpackage

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// Huffman header tree rebuild testbench
// Sends post-order tree headers in both header modes, directed cases first
// and then random trees, broken headers and noise, and checks every node
// record against a tree rebuilt inside the testbench.
// ============================================================================
module tb;

    import hhtr_pkg::*;
    import hhtr_tree_board_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 11;
    localparam int IDLE_PCT      = 37;
    localparam int RANDOM_ITEMS  = 480;
    // A packed byte of combines sends each combine through both engine states and
    // the command queue holds FIFO_DEPTH commands, so this covers any byte still
    // in flight that has no record to show for it.
    localparam int SETTLE_CYCLES = 64;
    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT   = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    // While steady is high neither side idles.
    logic steady;
    logic mode_now;
    int   live_items;
    int   stall_cycles = 0;

    // One command per entry: bit 8 set is a leaf with its value in [7:0],
    // bit 8 clear is a combine.
    logic [8:0] tree_cmds[$];
    logic       tree_bits[$];

    node_record_board board = new();

    hhtr_cfg_if cfg_ch();
    hhtr_hdr_if hdr_ch();
    hhtr_rec_if rec_ch();

    huffman_header_tree_rebuild DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_hdr   (hdr_ch),
        .o_rec   (rec_ch)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // The run is hung when no channel completes a transfer for too long.
    always @(posedge i_clk) begin
        if ((hdr_ch.valid && hdr_ch.ready) || (rec_ch.valid && rec_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("FAIL huffman_header_tree_rebuild");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // The record sink stalls at random, except during the steady stretch.
    initial begin
        rec_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rec_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Every record transfer is checked against the oldest expected record.
    always @(posedge i_clk) begin : rec_monitor
        t_rec got;
        if (i_rst_n === 1'b1 && rec_ch.valid === 1'b1 && rec_ch.ready === 1'b1) begin
            got.node_id      = rec_ch.node_id;
            got.is_leaf      = rec_ch.is_leaf;
            got.leaf_value   = rec_ch.leaf_value;
            got.left_id      = rec_ch.left_id;
            got.right_id     = rec_ch.right_id;
            got.tree_done    = rec_ch.tree_done;
            got.header_error = rec_ch.header_error;
            got.last_of_run  = rec_ch.last_of_run;
            board.match_record(got);
        end
    end

    // Sends one header byte. Valid is left high after the transfer, so that
    // a byte that follows at once keeps it high without a drop in between.
    task send_byte(logic [7:0] b, logic st);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            hdr_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        hdr_ch.valid        <= 1'b1;
        hdr_ch.header_byte  <= b;
        hdr_ch.start_header <= st;
        @(posedge i_clk);
        while (!hdr_ch.ready) @(posedge i_clk);
        if (board.take_header(b, st)) live_items++;
    endtask

    // The mode register is only written while the block is idle: every
    // expected record has come back and any silent byte has had time to
    // drain through the parser and the command queue.
    task write_header_mode(logic m);
        hdr_ch.valid <= 1'b0;
        while (board.pending_nodes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.header_mode <= m;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        board.mode = m;
        mode_now   = m;
    endtask

    // Builds a random well-formed post-order tree with the given leaf count.
    // The last command is the combine that finds the root alone on the stack.
    task build_tree(int leaves);
        int         held;
        int         left;
        logic [7:0] v;
        tree_cmds.delete();
        held = 0;
        left = leaves;
        while (left > 0 || held > 1) begin
            if (left > 0 && (held < 2 || $urandom_range(0, 1) == 1)) begin
                v = 8'($urandom);
                tree_cmds.push_back({1'b1, v});
                held++;
                left--;
            end else begin
                tree_cmds.push_back(9'h000);
                held--;
            end
        end
        tree_cmds.push_back(9'h000);
    endtask

    // Encodes commands lo..hi-1 in the current mode and sends them. Only the
    // first byte may carry start_header.
    task send_commands(int lo, int hi, logic st);
        int         k;
        int         n;
        logic [7:0] b;
        logic       first;
        first = st;
        if (mode_now == MODE_CHAR) begin
            for (k = lo; k < hi; k++) begin
                if (tree_cmds[k][8]) begin
                    send_byte(LEAF_CMD, first);
                    first = 1'b0;
                    send_byte(tree_cmds[k][7:0], 1'b0);
                end else begin
                    // Any byte other than the leaf code is a combine.
                    do b = 8'($urandom); while (b == LEAF_CMD);
                    send_byte(b, first);
                    first = 1'b0;
                end
            end
        end else begin
            tree_bits.delete();
            for (k = lo; k < hi; k++) begin
                tree_bits.push_back(tree_cmds[k][8]);
                if (tree_cmds[k][8])
                    for (n = 7; n >= 0; n--) tree_bits.push_back(tree_cmds[k][n]);
            end
            while (tree_bits.size() > 0) begin
                // Bits past the last command stay random.
                b = 8'($urandom);
                for (n = 7; n >= 0 && tree_bits.size() > 0; n--) b[n] = tree_bits.pop_front();
                send_byte(b, first);
                first = 1'b0;
            end
        end
    endtask

    // A packed header that runs into one of the two capacity errors. Either
    // one more leaf than the stack holds, or a chain of leaf and combine
    // pairs that keeps the stack shallow until the node ids run out.
    task overflow_run(bit by_nodes);
        int         k;
        logic [7:0] v;
        write_header_mode(MODE_PACKED);
        tree_cmds.delete();
        if (by_nodes) begin
            v = 8'($urandom);
            tree_cmds.push_back({1'b1, v});
            for (k = 0; k < DEF_MAX_NODES / 2; k++) begin
                v = 8'($urandom);
                tree_cmds.push_back({1'b1, v});
                tree_cmds.push_back(9'h000);
            end
        end else begin
            for (k = 0; k <= DEF_STACK_DEPTH; k++) begin
                v = 8'($urandom);
                tree_cmds.push_back({1'b1, v});
            end
        end
        send_commands(0, tree_cmds.size(), 1'b1);
    endtask

    initial begin : main
        int k;
        int kind;
        int split;
        int saved;
        bit stack_run_done;
        bit node_run_done;

        hdr_ch.valid        <= 1'b0;
        hdr_ch.header_byte  <= '0;
        hdr_ch.start_header <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.header_mode  <= MODE_CHAR;
        steady              <= 1'b0;
        i_rst_n             <= 1'b0;
        mode_now       = MODE_CHAR;
        live_items     = 0;
        stack_run_done = 1'b0;
        node_run_done  = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Character mode: a combine on an empty stack is an underflow, and
        // the byte after it is ignored until the next start. Then a two-leaf
        // tree with the smallest and largest symbols, a combine byte that is
        // not the leaf code, the root, and one ignored byte after it.
        write_header_mode(MODE_CHAR);
        send_byte(8'h00, 1'b1);
        send_byte(LEAF_CMD, 1'b0);
        send_byte(LEAF_CMD, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(LEAF_CMD, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h30, 1'b0);
        send_byte(8'h12, 1'b0);

        // Mode changes in the middle of a header. Seven value bits gathered
        // in packed mode are dropped when character mode takes the whole
        // next byte as the value. A leaf code read in character mode then
        // takes its value from eight packed bits.
        write_header_mode(MODE_PACKED);
        send_byte(8'hA5, 1'b1);
        write_header_mode(MODE_CHAR);
        send_byte(8'h3C, 1'b0);
        send_byte(LEAF_CMD, 1'b0);
        write_header_mode(MODE_PACKED);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);

        // Packed underflow on the very first command.
        send_byte(8'h00, 1'b1);

        // Nine leaves, the last one finished by bit 7 of 0x80, whose seven
        // zero bits then combine: eight records from a single byte. The
        // combines carry on into the next byte, where bit 6 pops the root.
        for (k = 0; k < 10; k++) send_byte(8'hFF, k == 0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);

        // Random part. Items swallowed by a finished or failed header and the
        // two capacity runs do not count toward the item total.
        live_items = 0;
        while (live_items < RANDOM_ITEMS) begin
            steady <= (live_items >= 200 && live_items < 290);
            if ($urandom_range(0, 4) == 0) write_header_mode(1'($urandom_range(0, 1)));
            saved = live_items;
            kind  = $urandom_range(0, 99);
            if (!stack_run_done && live_items >= 120) begin
                overflow_run(1'b0);
                stack_run_done = 1'b1;
                live_items     = saved;
            end else if (!node_run_done && live_items >= 330) begin
                overflow_run(1'b1);
                node_run_done = 1'b1;
                live_items    = saved;
            end else if (kind < 55) begin
                // Well-formed tree, mostly small, now and then a deeper one.
                build_tree(($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                       : $urandom_range(1, 12));
                send_commands(0, tree_cmds.size(), 1'b1);
            end else if (kind < 65) begin
                // Well-formed tree whose second part comes in the other mode.
                build_tree($urandom_range(1, 12));
                split = $urandom_range(1, tree_cmds.size() - 1);
                send_commands(0, split, 1'b1);
                write_header_mode(!mode_now);
                send_commands(split, tree_cmds.size(), 1'b0);
            end else if (kind < 80) begin
                // Mostly broken tree: cut short or now and then sent whole, or with one command turned around.
                build_tree($urandom_range(1, 12));
                split = $urandom_range(0, tree_cmds.size() - 1);
                if ($urandom_range(0, 1) == 1) begin
                    send_commands(0, split + 1, 1'b1);
                end else begin
                    tree_cmds[split][8]   = !tree_cmds[split][8];
                    tree_cmds[split][7:0] = 8'($urandom);
                    send_commands(0, tree_cmds.size(), 1'b1);
                end
            end else begin
                // Raw bytes, start_header now and then.
                for (k = $urandom_range(1, 6); k > 0; k--)
                    send_byte(8'($urandom), $urandom_range(0, 3) == 0);
            end
        end

        hdr_ch.valid <= 1'b0;
        while (board.pending_nodes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.fails == 0) begin
            $display("PASS huffman_header_tree_rebuild");
        end else begin
            $display("FAIL huffman_header_tree_rebuild");
        end
        $finish;
    end

endmodule
